// ===== hw/rtl/elastic_disk_collision_resolver_assert.svh =====
// Assertion macros shared by the collision resolver RTL.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ELASTIC_DISK_COLLISION_RESOLVER_ASSERT_SVH
`define ELASTIC_DISK_COLLISION_RESOLVER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define EDCR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define EDCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/edcr_pkg.sv =====
// Types and widths for the elastic disk collision resolver.
// No dependencies; the top, front and back RTL files import this package.
`timescale 1ns / 1ps

package edcr_pkg;

    // Quotient widths of the two division pipelines
    localparam int W6_W  = 23;  // normal velocity magnitude, Q17.6
    localparam int DV_W  = 19;  // velocity change magnitude, Q19.0

    typedef struct packed {
        logic signed [19:0] center_a_x;
        logic signed [19:0] center_a_y;
        logic signed [19:0] center_b_x;
        logic signed [19:0] center_b_y;
        logic        [17:0] radius_a;
        logic        [17:0] radius_b;
        logic signed [15:0] vel_a_x;
        logic signed [15:0] vel_a_y;
        logic signed [15:0] vel_b_x;
        logic signed [15:0] vel_b_y;
        logic        [15:0] mass_a;
        logic        [15:0] mass_b;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] new_vel_a_x;
        logic signed [15:0] new_vel_a_y;
        logic signed [15:0] new_vel_b_x;
        logic signed [15:0] new_vel_b_y;
        logic               collided;
        logic               saturated;
    } t_out_item;

    // Classified pair handed from the front to the back
    typedef struct packed {
        logic signed [15:0] vel_a_x;
        logic signed [15:0] vel_a_y;
        logic signed [15:0] vel_b_x;
        logic signed [15:0] vel_b_y;
        logic        [15:0] mass_a;
        logic        [15:0] mass_b;
        logic signed [20:0] n_x;
        logic signed [20:0] n_y;
        logic        [40:0] nn;
        logic signed [38:0] p;
        logic               hit;
    } t_job;

    // Side data carried alongside the divider lanes
    typedef struct packed {
        logic signed [15:0] vel_a_x;
        logic signed [15:0] vel_a_y;
        logic signed [15:0] vel_b_x;
        logic signed [15:0] vel_b_y;
        logic        [15:0] mass_a;
        logic        [15:0] mass_b;
        logic               hit;
        logic               neg_x;
        logic               neg_y;
    } t_bk_tag;

endpackage

// ===== hw/rtl/elastic_disk_collision_resolver.sv =====
// Elastic collision resolver for disk pairs: one pair in, one result out,
// one pair per clock when the result side keeps popping. After the edge that
// accepts its pair, a result passes two more front stages, the job queue, two
// back stages, the 23-stage normal projection divide, two mass product stages,
// the 19-stage mass split divide, the output register and the result queue
// before it can be popped. Both sides are queues: push/full in, empty/pop out.
// Front and back are separated by a job queue and stall on their own.
// Depends on edcr_pkg, edcr_front, edcr_back, edcr_pdiv and edcr_fifo.
`timescale 1ns / 1ps
`include "elastic_disk_collision_resolver_assert.svh"

module elastic_disk_collision_resolver #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  edcr_pkg::t_in_item  i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output edcr_pkg::t_out_item o_result
);
    import edcr_pkg::*;

    logic      job_push, job_full, job_empty, job_pop;
    t_job      job_in, job_out;
    logic      res_push, res_full;
    t_out_item res_in;

    edcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    edcr_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (MID_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    edcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_result    (res_in),
        .i_res_full  (res_full)
    );

    edcr_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    `EDCR_ASSERT(a_nohit_nosat, empty || o_result.collided || !o_result.saturated,
                 "saturation without collision")
    `EDCR_ASSERT(a_pop_pushes, !(job_pop && job_empty), "back took a job from an empty queue")
    `EDCR_ASSERT(a_res_room, !(res_push && res_full), "result pushed into a full queue")

endmodule

// ===== hw/rtl/edcr_fifo.sv =====
// Small register FIFO used as the job queue and the result queue.
// Stand-alone; includes the shared assertion macros.
`timescale 1ns / 1ps
`include "elastic_disk_collision_resolver_assert.svh"

module edcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `EDCR_ASSERT(a_fifo_not_both, !(o_full && o_empty), "fifo full and empty at once")
    `EDCR_ASSERT_NEXT(a_fifo_inc, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1, "fifo count did not grow")
    `EDCR_ASSERT_NEXT(a_fifo_dec, do_pop && !do_push, r_cnt == $past(r_cnt) - 1'b1, "fifo count did not shrink")

endmodule

// ===== hw/rtl/edcr_front.sv =====
// Front end: takes disk pairs, forms centre difference, overlap and approach
// tests and the projected relative speed. Depends on edcr_pkg.
`timescale 1ns / 1ps

module edcr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  edcr_pkg::t_in_item i_item,
    output logic               o_full,
    output logic               o_job_push,
    output edcr_pkg::t_job     o_job,
    input  logic               i_job_full
);
    import edcr_pkg::*;

    logic en;

    // stage 1: differences
    logic               n_coinc;
    logic signed [20:0] n_dx, n_dy;
    logic               r_v1;
    t_in_item           r1_item;
    logic signed [20:0] r1_dx, r1_dy, r1_nx, r1_ny;
    logic        [18:0] r1_rs;
    logic signed [16:0] r1_dva_x, r1_dva_y, r1_dvb_x, r1_dvb_y;
    logic signed [21:0] r1_pdx, r1_pdy;
    logic               r1_coinc;

    // stage 2: products
    logic               r_v2;
    t_in_item           r2_item;
    logic signed [41:0] r2_dx2, r2_dy2;
    logic        [37:0] r2_rs2;
    logic signed [38:0] r2_t1, r2_t2;
    logic signed [37:0] r2_u1, r2_u2;
    logic signed [20:0] r2_nx, r2_ny;
    logic               r2_coinc;

    // stage 3: sums and classification
    logic               r_v3;
    logic        [40:0] n_d2;
    logic signed [39:0] n_dot;
    logic signed [38:0] n_p;
    t_job               n_job;
    t_job               r_job;

    assign en         = !(r_v3 && i_job_full);
    assign o_full     = !en;
    assign o_job_push = r_v3 && !i_job_full;
    assign o_job      = r_job;

    always_comb begin
        n_dx = {i_item.center_b_x[19], i_item.center_b_x}
             - {i_item.center_a_x[19], i_item.center_a_x};
        n_dy = {i_item.center_b_y[19], i_item.center_b_y}
             - {i_item.center_a_y[19], i_item.center_a_y};
        n_coinc = (n_dx == '0) && (n_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item  <= i_item;
            r1_dx    <= n_dx;
            r1_dy    <= n_dy;
            r1_coinc <= n_coinc;
            // coincident centres push along x
            r1_nx    <= n_coinc ? 21'sd1 : n_dx;
            r1_ny    <= n_coinc ? 21'sd0 : n_dy;
            r1_rs    <= {1'b0, i_item.radius_a} + {1'b0, i_item.radius_b};
            r1_pdx   <= {n_dx[20], n_dx} + {4'b0, i_item.radius_a} - {4'b0, i_item.radius_b};
            r1_pdy   <= {n_dy[20], n_dy} + {4'b0, i_item.radius_a} - {4'b0, i_item.radius_b};
            r1_dva_x <= {i_item.vel_a_x[15], i_item.vel_a_x} - {i_item.vel_b_x[15], i_item.vel_b_x};
            r1_dva_y <= {i_item.vel_a_y[15], i_item.vel_a_y} - {i_item.vel_b_y[15], i_item.vel_b_y};
            r1_dvb_x <= {i_item.vel_b_x[15], i_item.vel_b_x} - {i_item.vel_a_x[15], i_item.vel_a_x};
            r1_dvb_y <= {i_item.vel_b_y[15], i_item.vel_b_y} - {i_item.vel_a_y[15], i_item.vel_a_y};

            r2_item  <= r1_item;
            r2_dx2   <= r1_dx * r1_dx;
            r2_dy2   <= r1_dy * r1_dy;
            r2_rs2   <= r1_rs * r1_rs;
            r2_t1    <= r1_dva_x * r1_pdx;
            r2_t2    <= r1_dva_y * r1_pdy;
            r2_u1    <= r1_dvb_x * r1_nx;
            r2_u2    <= r1_dvb_y * r1_ny;
            r2_nx    <= r1_nx;
            r2_ny    <= r1_ny;
            r2_coinc <= r1_coinc;

            r_job    <= n_job;
        end
    end

    always_comb begin
        n_d2  = {1'b0, r2_dx2[39:0]} + {1'b0, r2_dy2[39:0]};
        n_dot = {r2_t1[38], r2_t1} + {r2_t2[38], r2_t2};
        n_p   = {r2_u1[37], r2_u1} + {r2_u2[37], r2_u2};

        n_job.vel_a_x = r2_item.vel_a_x;
        n_job.vel_a_y = r2_item.vel_a_y;
        n_job.vel_b_x = r2_item.vel_b_x;
        n_job.vel_b_y = r2_item.vel_b_y;
        n_job.mass_a  = r2_item.mass_a;
        n_job.mass_b  = r2_item.mass_b;
        n_job.n_x     = r2_nx;
        n_job.n_y     = r2_ny;
        n_job.nn      = r2_coinc ? 41'd1 : n_d2;
        n_job.p       = n_p;
        n_job.hit     = (n_d2 <= {3'b0, r2_rs2})
                     && ((r2_item.mass_a | r2_item.mass_b) != '0)
                     && !n_dot[39];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

endmodule

// ===== hw/rtl/edcr_pdiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one denominator, with side data carried along. No dependencies.
`timescale 1ns / 1ps

module edcr_pdiv #(
    parameter int LANES = 2,
    parameter int NUM_W = 64,
    parameter int DEN_W = 41,
    parameter int QUO_W = 23,
    parameter int TAG_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_valid,
    output logic [LANES-1:0][QUO_W-1:0] o_quo,
    output logic [TAG_W-1:0]            o_tag
);
    // numerator must stay below den << QUO_W
    localparam int REM_W = DEN_W + QUO_W;

    logic [QUO_W-1:0]              r_v;
    logic [LANES-1:0][REM_W-1:0]   r_rem [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]   r_quo [QUO_W];
    logic [DEN_W-1:0]              r_den [QUO_W];
    logic [TAG_W-1:0]              r_tag [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int SH = QUO_W - 1 - j;

        logic                        v_in;
        logic [LANES-1:0][REM_W-1:0] rem_in;
        logic [LANES-1:0][QUO_W-1:0] quo_in;
        logic [DEN_W-1:0]            den_in;
        logic [TAG_W-1:0]            tag_in;
        logic [REM_W-1:0]            den_sh;
        logic [LANES-1:0][REM_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0] n_quo;

        if (j == 0) begin : g_first
            always_comb begin
                v_in   = i_valid;
                den_in = i_den;
                tag_in = i_tag;
                quo_in = '0;
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = REM_W'(i_num[l]);
                end
            end
        end else begin : g_next
            always_comb begin
                v_in   = r_v[j-1];
                den_in = r_den[j-1];
                tag_in = r_tag[j-1];
                quo_in = r_quo[j-1];
                rem_in = r_rem[j-1];
            end
        end

        assign den_sh = REM_W'(den_in) << SH;

        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= den_sh) begin
                    n_rem[l]     = rem_in[l] - den_sh;
                    n_quo[l][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_quo[j] <= n_quo;
                r_den[j] <= den_in;
                r_tag[j] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_tag   = r_tag[QUO_W-1];

endmodule

// ===== hw/rtl/edcr_back.sv =====
// Back end: projects the relative speed onto the centre line, splits it by
// mass and applies it with saturation. Depends on edcr_pkg and edcr_pdiv.
`timescale 1ns / 1ps

module edcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  edcr_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_res_push,
    output edcr_pkg::t_out_item o_result,
    input  logic                i_res_full
);
    import edcr_pkg::*;

    localparam int TAG_W = $bits(t_bk_tag);

    // adds a signed change given as magnitude and sign; returns {sat, value}
    function automatic logic [16:0] f_add_sat(input logic signed [15:0] v,
                                              input logic [DV_W-1:0] mag,
                                              input logic sub);
        logic signed [20:0] d;
        logic signed [20:0] s;
        logic [16:0]        res;
        d = sub ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        s = {{5{v[15]}}, v} + d;
        if (s > 21'sd32767) begin
            res = {1'b1, 16'h7fff};
        end else if (s < -21'sd32768) begin
            res = {1'b1, 16'h8000};
        end else begin
            res = {1'b0, s[15:0]};
        end
        return res;
    endfunction

    logic en;

    // B0: magnitudes and split partial products of p * n
    logic               n_p_neg;
    logic [37:0]        n_pm;
    logic [19:0]        n_nmx, n_nmy;
    t_bk_tag            n_tag0;
    logic               r0_v;
    logic [38:0]        r0_lo_x, r0_hi_x, r0_lo_y, r0_hi_y;
    logic [40:0]        r0_nn;
    t_bk_tag            r0_tag;

    // B1: first divider numerators
    logic [57:0]        n_qx, n_qy;
    logic               r1_v;
    logic [1:0][63:0]   r1_num;
    logic [40:0]        r1_nn;
    t_bk_tag            r1_tag;

    logic               d1_v;
    logic [1:0][W6_W-1:0] d1_quo;
    logic [TAG_W-1:0]   d1_tag_bits;
    t_bk_tag            d1_tag;

    // M1: mass products
    logic               rm1_v;
    logic [38:0]        rm1_am_x, rm1_bm_x, rm1_am_y, rm1_bm_y;
    logic [16:0]        rm1_msum;
    t_bk_tag            rm1_tag;

    // M2: second divider numerators
    logic               rm2_v;
    logic [3:0][40:0]   rm2_num;
    logic [22:0]        rm2_den;
    t_bk_tag            rm2_tag;
    logic [40:0]        n_half;

    logic               d2_v;
    logic [3:0][DV_W-1:0] d2_quo;
    logic [TAG_W-1:0]   d2_tag_bits;
    t_bk_tag            d2_tag;

    logic [16:0]        s_ax, s_ay, s_bx, s_by;
    t_out_item          n_out;
    logic               r_out_v;
    t_out_item          r_out;

    assign en         = !(r_out_v && i_res_full);
    assign o_job_pop  = en && i_job_valid;
    assign o_res_push = r_out_v && !i_res_full;
    assign o_result   = r_out;

    always_comb begin
        n_p_neg = i_job.p[38];
        n_pm    = 38'(n_p_neg ? -i_job.p : i_job.p);
        n_nmx   = 20'(i_job.n_x[20] ? -i_job.n_x : i_job.n_x);
        n_nmy   = 20'(i_job.n_y[20] ? -i_job.n_y : i_job.n_y);
        n_tag0.vel_a_x = i_job.vel_a_x;
        n_tag0.vel_a_y = i_job.vel_a_y;
        n_tag0.vel_b_x = i_job.vel_b_x;
        n_tag0.vel_b_y = i_job.vel_b_y;
        n_tag0.mass_a  = i_job.mass_a;
        n_tag0.mass_b  = i_job.mass_b;
        n_tag0.hit     = i_job.hit;
        n_tag0.neg_x   = n_p_neg ^ i_job.n_x[20];
        n_tag0.neg_y   = n_p_neg ^ i_job.n_y[20];
    end

    always_comb begin
        n_qx   = {r0_hi_x, 19'b0} + 58'(r0_lo_x);
        n_qy   = {r0_hi_y, 19'b0} + 58'(r0_lo_y);
        n_half = 41'({rm1_msum, 5'b0});
    end

    assign d1_tag = t_bk_tag'(d1_tag_bits);
    assign d2_tag = t_bk_tag'(d2_tag_bits);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_lo_x <= n_pm[18:0] * n_nmx;
            r0_hi_x <= n_pm[37:19] * n_nmx;
            r0_lo_y <= n_pm[18:0] * n_nmy;
            r0_hi_y <= n_pm[37:19] * n_nmy;
            r0_nn   <= i_job.nn;
            r0_tag  <= n_tag0;

            // rounding: add half the divisor before the floor divide
            r1_num[0] <= {n_qx, 6'b0} + 64'(r0_nn[40:1]);
            r1_num[1] <= {n_qy, 6'b0} + 64'(r0_nn[40:1]);
            r1_nn     <= r0_nn;
            r1_tag    <= r0_tag;

            rm1_am_x <= d1_tag.mass_b * d1_quo[0];
            rm1_bm_x <= d1_tag.mass_a * d1_quo[0];
            rm1_am_y <= d1_tag.mass_b * d1_quo[1];
            rm1_bm_y <= d1_tag.mass_a * d1_quo[1];
            rm1_msum <= {1'b0, d1_tag.mass_a} + {1'b0, d1_tag.mass_b};
            rm1_tag  <= d1_tag;

            rm2_num[0] <= {rm1_am_x, 1'b0} + n_half;
            rm2_num[1] <= {rm1_bm_x, 1'b0} + n_half;
            rm2_num[2] <= {rm1_am_y, 1'b0} + n_half;
            rm2_num[3] <= {rm1_bm_y, 1'b0} + n_half;
            rm2_den    <= {rm1_msum, 6'b0};
            rm2_tag    <= rm1_tag;

            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            rm1_v   <= 1'b0;
            rm2_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r0_v    <= i_job_valid;
            r1_v    <= r0_v;
            rm1_v   <= d1_v;
            rm2_v   <= rm1_v;
            r_out_v <= d2_v;
        end
    end

    edcr_pdiv #(
        .LANES (2),
        .NUM_W (64),
        .DEN_W (41),
        .QUO_W (W6_W),
        .TAG_W (TAG_W)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (r1_num),
        .i_den   (r1_nn),
        .i_tag   (r1_tag),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag_bits)
    );

    edcr_pdiv #(
        .LANES (4),
        .NUM_W (41),
        .DEN_W (23),
        .QUO_W (DV_W),
        .TAG_W (TAG_W)
    ) u_div_mass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rm2_v),
        .i_num   (rm2_num),
        .i_den   (rm2_den),
        .i_tag   (rm2_tag),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag_bits)
    );

    // lanes: 0 a-change x, 1 b-change x, 2 a-change y, 3 b-change y
    always_comb begin
        s_ax = f_add_sat(d2_tag.vel_a_x, d2_quo[0], d2_tag.neg_x);
        s_bx = f_add_sat(d2_tag.vel_b_x, d2_quo[1], !d2_tag.neg_x);
        s_ay = f_add_sat(d2_tag.vel_a_y, d2_quo[2], d2_tag.neg_y);
        s_by = f_add_sat(d2_tag.vel_b_y, d2_quo[3], !d2_tag.neg_y);
        if (d2_tag.hit) begin
            n_out.new_vel_a_x = s_ax[15:0];
            n_out.new_vel_a_y = s_ay[15:0];
            n_out.new_vel_b_x = s_bx[15:0];
            n_out.new_vel_b_y = s_by[15:0];
            n_out.collided    = 1'b1;
            n_out.saturated   = s_ax[16] | s_ay[16] | s_bx[16] | s_by[16];
        end else begin
            n_out.new_vel_a_x = d2_tag.vel_a_x;
            n_out.new_vel_a_y = d2_tag.vel_a_y;
            n_out.new_vel_b_x = d2_tag.vel_b_x;
            n_out.new_vel_b_y = d2_tag.vel_b_y;
            n_out.collided    = 1'b0;
            n_out.saturated   = 1'b0;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for elastic_disk_collision_resolver: random and directed
// disk pairs, predicted velocities and flags compared item by item. Needs edcr_pkg and the RTL.
`timescale 1ns / 1ps

class collision_scoreboard;
    edcr_pkg::t_out_item pending[$];
    int errors;

    function longint rnd_div(longint num, longint den);
        return (num + den / 2) / den;
    endfunction

    function longint clip16(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1;
            return -32768;
        end
        return v;
    endfunction

    function void note_pair(edcr_pkg::t_in_item it);
        edcr_pkg::t_out_item r;
        longint dx, dy, d2, rs, dot, p, q, w6, den, am, bm, msum;
        longint nv[2], da[2], db[2];
        longint vax, vay, vbx, vby, ra, rb;
        bit sat;
        bit hit;
        sat = 0;
        hit = 0;
        vax = it.vel_a_x; vay = it.vel_a_y; vbx = it.vel_b_x; vby = it.vel_b_y;
        ra = it.radius_a; rb = it.radius_b;
        msum = longint'(it.mass_a) + longint'(it.mass_b);
        dx = longint'(it.center_b_x) - longint'(it.center_a_x);
        dy = longint'(it.center_b_y) - longint'(it.center_a_y);
        d2 = dx * dx + dy * dy;
        rs = ra + rb;
        da[0] = 0; da[1] = 0; db[0] = 0; db[1] = 0;
        if (d2 <= rs * rs && msum != 0) begin
            // approach test uses top-left corners, not centers
            dot = (vax - vbx) * (dx - rb + ra) + (vay - vby) * (dy - rb + ra);
            if (dot >= 0) begin
                hit = 1;
                nv[0] = dx; nv[1] = dy;
                if (d2 == 0) begin
                    nv[0] = 1; nv[1] = 0; d2 = 1;
                end
                p = (vbx - vax) * nv[0] + (vby - vay) * nv[1];
                for (int c = 0; c < 2; c++) begin
                    q = p * nv[c];
                    w6 = rnd_div((q < 0 ? -q : q) * 64, d2);
                    den = msum * 64;
                    am = rnd_div(2 * longint'(it.mass_b) * w6, den);
                    bm = rnd_div(2 * longint'(it.mass_a) * w6, den);
                    da[c] = (q < 0) ? -am : am;
                    db[c] = (q < 0) ? bm : -bm;
                end
            end
        end
        r.new_vel_a_x = 16'(clip16(vax + da[0], sat));
        r.new_vel_a_y = 16'(clip16(vay + da[1], sat));
        r.new_vel_b_x = 16'(clip16(vbx + db[0], sat));
        r.new_vel_b_y = 16'(clip16(vby + db[1], sat));
        r.collided = hit;
        r.saturated = sat;
        pending.push_back(r);
    endfunction

    function void check_result(edcr_pkg::t_out_item got);
        edcr_pkg::t_out_item e;
        if (pending.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.new_vel_a_x !== e.new_vel_a_x) begin
            $error("new_vel_a_x exp %0d got %0d", e.new_vel_a_x, got.new_vel_a_x);
            errors++;
        end
        if (got.new_vel_a_y !== e.new_vel_a_y) begin
            $error("new_vel_a_y exp %0d got %0d", e.new_vel_a_y, got.new_vel_a_y);
            errors++;
        end
        if (got.new_vel_b_x !== e.new_vel_b_x) begin
            $error("new_vel_b_x exp %0d got %0d", e.new_vel_b_x, got.new_vel_b_x);
            errors++;
        end
        if (got.new_vel_b_y !== e.new_vel_b_y) begin
            $error("new_vel_b_y exp %0d got %0d", e.new_vel_b_y, got.new_vel_b_y);
            errors++;
        end
        if (got.collided !== e.collided) begin
            $error("collided exp %0d got %0d", e.collided, got.collided);
            errors++;
        end
        if (got.saturated !== e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import edcr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM = 1100;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty;
    t_in_item i_item = '0;
    t_out_item o_result;

    collision_scoreboard sb = new();
    bit calm = 0;   // no idling on either side while set
    bit src_done = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    elastic_disk_collision_resolver u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item),
        .full(full), .empty(empty), .pop(pop), .o_result(o_result)
    );

    function bit idle_now();
        return !calm && $urandom_range(99) < 14;
    endfunction

    // push stays high between items sent back to back
    task automatic send_pair(t_in_item it);
        while (idle_now()) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_pair(it);
    endtask

    // center b placed within reach of a, mostly small geometry to get hits
    function automatic t_in_item near_pair();
        t_in_item it;
        logic [223:0] raw;
        int span;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        span = $urandom_range(3) == 0 ? 262143 : 4095;
        it.radius_a = 18'($urandom_range(span));
        it.radius_b = 18'($urandom_range(span));
        it.center_b_x = it.center_a_x + 20'($signed($urandom_range(2 * span)) - span);
        it.center_b_y = it.center_a_y + 20'($signed($urandom_range(2 * span)) - span);
        if ($urandom_range(7) == 0) it.center_b_x = it.center_a_x;
        if ($urandom_range(7) == 0) it.center_b_y = it.center_a_y;
        if ($urandom_range(1)) begin
            it.vel_a_x = 16'($signed($urandom_range(1024)) - 512);
            it.vel_a_y = 16'($signed($urandom_range(1024)) - 512);
            it.vel_b_x = 16'($signed($urandom_range(1024)) - 512);
            it.vel_b_y = 16'($signed($urandom_range(1024)) - 512);
        end
        it.mass_a = 16'($urandom_range(65535, 1));
        it.mass_b = 16'($urandom_range(65535, 1));
        if ($urandom_range(9) == 0) it.mass_a = 0;
        else if ($urandom_range(9) == 0) it.mass_b = 0;
        return it;
    endfunction

    function automatic t_in_item pair_of(int ax, int ay, int bx, int by, int ra, int rb,
                                         int vax, int vay, int vbx, int vby, int ma, int mb);
        t_in_item it;
        it.center_a_x = 20'(ax); it.center_a_y = 20'(ay);
        it.center_b_x = 20'(bx); it.center_b_y = 20'(by);
        it.radius_a = 18'(ra); it.radius_b = 18'(rb);
        it.vel_a_x = 16'(vax); it.vel_a_y = 16'(vay);
        it.vel_b_x = 16'(vbx); it.vel_b_y = 16'(vby);
        it.mass_a = 16'(ma); it.mass_b = 16'(mb);
        return it;
    endfunction

    initial begin
        t_in_item it;
        logic [223:0] raw;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // head-on with equal masses, then oblique with unequal masses
        send_pair(pair_of(0, 0, 2560, 0, 1280, 1280, 256, 0, -256, 0, 256, 256));
        send_pair(pair_of(0, 0, 1000, 1000, 1280, 1280, 300, 200, -100, -50, 256, 768));
        // separating: no exchange
        send_pair(pair_of(0, 0, 2560, 0, 1280, 1280, -256, 0, 256, 0, 256, 256));
        // too far apart
        send_pair(pair_of(0, 0, 100000, 0, 10, 10, 256, 0, -256, 0, 256, 256));
        // coincident centers
        send_pair(pair_of(500, 500, 500, 500, 100, 100, 300, 7, -300, 9, 256, 256));
        send_pair(pair_of(-5, 9, -5, 9, 0, 0, 0, 0, 0, 0, 1, 1));
        // zero masses
        send_pair(pair_of(0, 0, 256, 0, 256, 256, 256, 0, -256, 0, 0, 0));
        send_pair(pair_of(0, 0, 256, 0, 256, 256, 256, 0, -256, 0, 0, 512));
        send_pair(pair_of(0, 0, 256, 0, 256, 256, 256, 0, -256, 0, 512, 0));
        // saturation, field extremes and an overlapping pair at rest
        send_pair(pair_of(0, 0, 1, 1, 10, 10, 32767, 32767, -32768, -32768, 1, 65535));
        send_pair(pair_of(0, 0, -1, 0, 10, 10, -32768, 0, 32767, 0, 65535, 1));
        send_pair(pair_of(-524288, -524288, 524287, 524287, 262143, 262143,
                          32767, -32768, -32768, 32767, 65535, 65535));
        send_pair(pair_of(524287, -524288, 524287, -524288, 262143, 0,
                          -1, 1, 1, -1, 65535, 1));
        send_pair(pair_of(0, 0, 0, 300, 200, 200, 0, 0, 0, 0, 256, 256));
        // pause until everything drains
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 400 && k < 550);
            if ($urandom_range(9) < 8) begin
                it = near_pair();
            end else begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom};
                it = raw[$bits(t_in_item)-1:0];
            end
            if (k == 700) begin
                push <= 0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            send_pair(it);
        end
        push <= 0;
        src_done = 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
        end else begin
            if (pop && !empty) sb.check_result(o_result);
            pop <= !idle_now();
        end
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (src_done && sb.pending.size() == 0 && quiet_cycles > 100) begin
            if (sb.errors == 0 && empty) begin
                $display("elastic_disk_collision_resolver test passed");
            end else begin
                $display("elastic_disk_collision_resolver test failed");
            end
            $finish;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("elastic_disk_collision_resolver test failed");
            $finish;
        end
    end
endmodule

// ===== elastic_disk_collision_resolver.f =====
+incdir+hw/rtl
hw/rtl/edcr_pkg.sv
hw/rtl/edcr_fifo.sv
hw/rtl/edcr_front.sv
hw/rtl/edcr_pdiv.sv
hw/rtl/edcr_back.sv
hw/rtl/elastic_disk_collision_resolver.sv
dv/tb_top.sv
